// ===== design/irft_pkg.sv =====
package irft_pkg;

  // Frame phases of the transmitter
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LMARK  = 3'd1,
    PH_LSPACE = 3'd2,
    PH_BMARK  = 3'd3,
    PH_BSPACE = 3'd4,
    PH_STOP   = 3'd5
  } phase_t;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_COMMAND_CODE   = 1'b1;

  localparam logic [15:0] DEVICE_ADDRESS_RST = 16'h00F7;
  localparam logic [7:0]  COMMAND_CODE_RST   = 8'hC0;

  // Space lengths of a data bit, in ticks
  localparam logic [4:0] ONE_SPACE_TICKS  = 5'd3;
  localparam logic [4:0] ZERO_SPACE_TICKS = 5'd1;

  // One result item
  typedef struct packed {
    logic frame_done;
    logic busy_res;
    logic carrier_enable;
  } result_t;

endpackage

// ===== design/irft_seq.sv =====
module irft_seq #(
  parameter int LEADER_MARK_TICKS  = 16,
  parameter int LEADER_SPACE_TICKS = 8,
  parameter int ADDRESS_BITS       = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick,
  input  logic                start_request,
  input  logic [15:0]         device_address,
  input  logic [7:0]          command_code,
  output irft_pkg::result_t   result,
  output irft_pkg::phase_t    phase,
  output logic [4:0]          tick_counter
);
  import irft_pkg::*;

  localparam int TOTAL_BITS = ADDRESS_BITS + 16;
  localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDRESS_BITS) - 32'd1);

  phase_t      phase_next;
  logic [4:0]  tick_counter_next;
  logic [5:0]  bits_left;
  logic [5:0]  bits_left_next;
  logic [31:0] frame_shift;
  logic [31:0] frame_shift_next;
  logic [31:0] frame_word;
  logic [4:0]  tick_inc;
  logic [4:0]  tick_dec;
  logic [5:0]  bits_dec;
  phase_t      cur;

  // Frame bits left-aligned: address, command, inverted command
  assign frame_word = {(device_address & ADDR_MASK), command_code, ~command_code}
                      << (16 - ADDRESS_BITS);

  // Next-state logic for one tick
  always_comb begin
    phase_next        = phase;
    tick_counter_next = tick_counter;
    bits_left_next    = bits_left;
    frame_shift_next  = frame_shift;
    result            = '0;
    result.busy_res   = 1'b1;
    cur               = phase;

    if (phase == PH_IDLE && start_request) begin
      frame_shift_next  = frame_word;
      cur               = PH_LMARK;
      phase_next        = PH_LMARK;
      tick_counter_next = '0;
    end

    tick_inc = tick_counter_next + 5'd1;
    tick_dec = tick_counter_next - 5'd1;
    bits_dec = bits_left - 6'd1;

    case (cur)
      PH_LMARK: begin
        result.carrier_enable = 1'b1;
        tick_counter_next     = tick_inc;
        if (tick_inc >= 5'(LEADER_MARK_TICKS)) begin
          phase_next        = PH_LSPACE;
          tick_counter_next = '0;
        end
      end
      PH_LSPACE: begin
        tick_counter_next = tick_inc;
        if (tick_inc >= 5'(LEADER_SPACE_TICKS)) begin
          phase_next        = PH_BMARK;
          tick_counter_next = '0;
          bits_left_next    = 6'(TOTAL_BITS);
        end
      end
      PH_BMARK: begin
        result.carrier_enable = 1'b1;
        tick_counter_next = frame_shift[31] ? ONE_SPACE_TICKS : ZERO_SPACE_TICKS;
        phase_next        = PH_BSPACE;
      end
      PH_BSPACE: begin
        tick_counter_next = tick_dec;
        if (tick_dec == 5'd0) begin
          frame_shift_next = {frame_shift[30:0], 1'b0};
          bits_left_next   = bits_dec;
          phase_next       = (bits_dec == 6'd0) ? PH_STOP : PH_BMARK;
        end
      end
      PH_STOP: begin
        result.carrier_enable = 1'b1;
        result.frame_done     = 1'b1;
        phase_next            = PH_IDLE;
        tick_counter_next     = '0;
      end
      default: begin
        result.busy_res = 1'b0;
        phase_next      = PH_IDLE;
      end
    endcase
  end

  // State registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_counter <= '0;
      bits_left    <= '0;
      frame_shift  <= '0;
    end else if (tick) begin
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      bits_left    <= bits_left_next;
      frame_shift  <= frame_shift_next;
    end
  end

endmodule

// ===== design/irft_out.sv =====
module irft_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  irft_pkg::result_t in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output irft_pkg::result_t out_res
);
  import irft_pkg::*;

  result_t main_res;
  result_t skid_res;
  logic    main_valid;
  logic    skid_valid;
  logic    push;
  logic    pop;

  assign in_ready  = !skid_valid;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid && out_ready;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  // Control: main register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_res <= skid_res;
      end else if (push) begin
        main_res <= in_res;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_res <= in_res;
      end else begin
        skid_res <= in_res;
      end
    end
  end

endmodule

// ===== design/ir_frame_transmitter.sv =====
// Pulse-distance infrared frame transmitter.
// Input stream (s_*): one item per bit-time tick; s_tdata[0] is a start
// request, honored only while no frame is in progress. The address and
// command registers are sampled on the tick that starts a frame.
// Output stream (m_*): exactly one item per input item, carrying the
// carrier enable, busy flag and frame-done marker for that tick.
// Frame: leader mark, leader space, address bits, command, inverted command
// (MSB first, 1-tick mark then 3- or 1-tick space), then a 1-tick stop mark.
// Each result is registered in the output stage before it appears on m_*.
// Throughput: one item per cycle while s_tready is high; the sequencer's next state is combinational.
// Stall: a main output register plus one skid entry; s_tready drops only
// when both hold results, so a tick is taken while a result waits.
// Reset (rst, synchronous): sequencer idle, output empty, address 0x00F7,
// command 0xC0.
// Config (APB): device_address at 0x0, command_code at 0x4, paddr[2] selects.
module ir_frame_transmitter #(
  parameter int LEADER_MARK_TICKS  = 16,
  parameter int LEADER_SPACE_TICKS = 8,
  parameter int ADDRESS_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] start_request, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] carrier_enable, [1] busy_res, [2] frame_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import irft_pkg::*;

  logic [15:0] device_address;
  logic [7:0]  command_code;
  logic        cfg_write;
  logic        tick;
  result_t     seq_res;
  result_t     out_res;
  phase_t      phase;
  logic [4:0]  tick_counter;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RST;
      command_code   <= COMMAND_CODE_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_DEVICE_ADDRESS: device_address <= pwdata[15:0];
        REG_COMMAND_CODE:   command_code   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEVICE_ADDRESS: prdata = {16'd0, device_address};
      REG_COMMAND_CODE:   prdata = {24'd0, command_code};
      default:            prdata = '0;
    endcase
  end

  assign tick = s_tvalid && s_tready;

  irft_seq #(
    .LEADER_MARK_TICKS (LEADER_MARK_TICKS),
    .LEADER_SPACE_TICKS(LEADER_SPACE_TICKS),
    .ADDRESS_BITS      (ADDRESS_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .start_request (s_tdata[0]),
    .device_address(device_address),
    .command_code  (command_code),
    .result        (seq_res),
    .phase         (phase),
    .tick_counter  (tick_counter)
  );

  irft_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_res   (seq_res),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (out_res)
  );

  assign m_tdata = {5'd0, out_res.frame_done, out_res.busy_res, out_res.carrier_enable};

  // A frame-done result is always a busy mark tick
  a_done_is_mark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[0] && m_tdata[1])
    else $error("frame_done without carrier and busy");

  // The stop tick always returns the sequencer to idle
  a_stop_to_idle: assert property (@(posedge clk) disable iff (rst)
    tick && phase == PH_STOP |=> phase == PH_IDLE)
    else $error("stop tick did not return to idle");

  // A bit space always has ticks left to count
  a_space_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BSPACE |-> tick_counter != 5'd0)
    else $error("bit space with zero tick count");

  // Input stalls only when the output holds a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

endmodule

// ===== sim/tb_ir_frame_transmitter.sv =====
`timescale 1ns / 1ps

module tb_ir_frame_transmitter;
  import irft_pkg::*;

  localparam int LEADER_MARK_TICKS  = 16;
  localparam int LEADER_SPACE_TICKS = 8;
  localparam int ADDRESS_BITS       = 16;
  localparam int FRAME_BITS         = ADDRESS_BITS + 16;
  localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDRESS_BITS) - 1);
  localparam int STUCK_LIMIT        = 2000;
  localparam int PHASE_TICKS        = 125;
  localparam int NUM_PHASES         = 5;

  // Fixed result patterns, low bit is carrier_enable
  localparam result_t R_IDLE = 3'b000;
  localparam result_t R_MARK = 3'b011;
  localparam result_t R_STOP = 3'b111;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;   // [0] start_request, [7:1] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [0] carrier_enable, [1] busy_res, [2] frame_done
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = 3'd0;
  logic [31:0] pwdata   = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  ir_frame_transmitter #(
    .LEADER_MARK_TICKS (LEADER_MARK_TICKS),
    .LEADER_SPACE_TICKS(LEADER_SPACE_TICKS),
    .ADDRESS_BITS      (ADDRESS_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Transmitter mirror: registers and sequencer state
  logic [15:0] addr_reg  = DEVICE_ADDRESS_RST;
  logic [7:0]  cmd_reg   = COMMAND_CODE_RST;
  phase_t      tx_phase  = PH_IDLE;
  logic [4:0]  tick_cnt  = '0;
  logic [5:0]  bits_left = '0;
  logic [31:0] frame_reg = '0;

  result_t awaited_ticks[$];
  int      err_count     = 0;
  int      ticks_checked = 0;
  int      frames_done   = 0;
  int      reg_writes    = 0;
  bit      tx_idle_on    = 1'b1;
  bit      rx_idle_on    = 1'b1;
  int      rx_stall      = 0;
  int      stuck_cycles  = 0;
  result_t got_tick, want_tick;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // One tick of the sequencer; frame bits are latched on the start tick
  function automatic result_t predict_ir_tick(input bit start);
    result_t     r;
    logic [31:0] word;
    r = R_IDLE;
    r.busy_res = 1'b1;
    if (tx_phase == PH_IDLE && start) begin
      word = {addr_reg & ADDR_MASK, cmd_reg, ~cmd_reg};
      frame_reg = word << (32 - FRAME_BITS);
      tx_phase = PH_LMARK;
      tick_cnt = '0;
    end
    case (tx_phase)
      PH_LMARK: begin
        r.carrier_enable = 1'b1;
        tick_cnt = tick_cnt + 5'd1;
        if (tick_cnt >= LEADER_MARK_TICKS) begin
          tx_phase = PH_LSPACE;
          tick_cnt = '0;
        end
      end
      PH_LSPACE: begin
        tick_cnt = tick_cnt + 5'd1;
        if (tick_cnt >= LEADER_SPACE_TICKS) begin
          tx_phase = PH_BMARK;
          tick_cnt = '0;
          bits_left = 6'(FRAME_BITS);
        end
      end
      PH_BMARK: begin
        r.carrier_enable = 1'b1;
        tick_cnt = frame_reg[31] ? ONE_SPACE_TICKS : ZERO_SPACE_TICKS;
        tx_phase = PH_BSPACE;
      end
      PH_BSPACE: begin
        tick_cnt = tick_cnt - 5'd1;
        if (tick_cnt == 0) begin
          frame_reg = frame_reg << 1;
          bits_left = bits_left - 6'd1;
          tx_phase = (bits_left == 0) ? PH_STOP : PH_BMARK;
        end
      end
      PH_STOP: begin
        r.carrier_enable = 1'b1;
        r.frame_done = 1'b1;
        tx_phase = PH_IDLE;
        tick_cnt = '0;
      end
      default: begin
        r.busy_res = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Send one tick; a typed row overrides the predicted result
  task automatic send_tick(input bit start, input bit typed, input result_t want);
    int      gap;
    result_t r;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, start};
    do @(posedge clk); while (!s_tready);
    r = predict_ir_tick(start);
    awaited_ticks.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (awaited_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic read_reg(input logic idx, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write, update the mirror, then read back
  task automatic write_reg(input logic idx, input logic [31:0] val);
    logic [31:0] rd, masked;
    masked = (idx == REG_DEVICE_ADDRESS) ? {16'd0, val[15:0]} : {24'd0, val[7:0]};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_DEVICE_ADDRESS) addr_reg = val[15:0];
    else cmd_reg = val[7:0];
    reg_writes++;
    read_reg(idx, rd);
    if (rd !== masked) report_mismatch("register readback", rd, masked);
  endtask

  // Output side: check each item and draw the next stall
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_tick = m_tdata[2:0];
      if (awaited_ticks.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(got_tick), 32'd0);
      end else begin
        want_tick = awaited_ticks.pop_front();
        ticks_checked++;
        if (got_tick.carrier_enable !== want_tick.carrier_enable)
          report_mismatch("carrier_enable", 32'(got_tick.carrier_enable),
                          32'(want_tick.carrier_enable));
        if (got_tick.busy_res !== want_tick.busy_res)
          report_mismatch("busy_res", 32'(got_tick.busy_res), 32'(want_tick.busy_res));
        if (got_tick.frame_done !== want_tick.frame_done)
          report_mismatch("frame_done", 32'(got_tick.frame_done),
                          32'(want_tick.frame_done));
        if (want_tick.frame_done) frames_done++;
      end
    end
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall = 0;
    end else if (m_tvalid && m_tready) begin
      rx_stall = rx_idle_on ? $urandom_range(0, 3) : 0;
      m_tready <= (rx_stall == 0);
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= (rx_stall == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", STUCK_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  typedef struct {
    bit      start;
    int      reps;
    bit      typed;
    result_t want;
  } dir_row_t;

  dir_row_t    dir_rows [7];
  int          req_pct  [NUM_PHASES];
  logic [31:0] rd_val;
  logic [15:0] next_addr;
  logic [7:0]  next_cmd;

  initial begin
    // With reset registers the first frame is 119 ticks long
    dir_rows = '{
      '{1'b0, 2,   1'b1, R_IDLE},   // idle after reset
      '{1'b1, 1,   1'b1, R_MARK},   // start tick is the first leader mark tick
      '{1'b1, 5,   1'b0, R_IDLE},   // requests during a frame are ignored
      '{1'b0, 112, 1'b0, R_IDLE},   // rest of the frame up to the stop mark
      '{1'b0, 1,   1'b1, R_STOP},   // stop mark
      '{1'b1, 1,   1'b1, R_MARK},   // back-to-back start right after stop
      '{1'b0, 3,   1'b0, R_IDLE}
    };
    req_pct = '{95, 100, 15, 60, 40};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values of the registers
    read_reg(REG_DEVICE_ADDRESS, rd_val);
    if (rd_val !== {16'd0, DEVICE_ADDRESS_RST})
      report_mismatch("device_address after reset", rd_val, {16'd0, DEVICE_ADDRESS_RST});
    read_reg(REG_COMMAND_CODE, rd_val);
    if (rd_val !== {24'd0, COMMAND_CODE_RST})
      report_mismatch("command_code after reset", rd_val, {24'd0, COMMAND_CODE_RST});

    // Directed rows
    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++)
        send_tick(dir_rows[r].start, dir_rows[r].typed, dir_rows[r].want);
    end

    // Random phases; the first write lands mid-frame, so the frame must keep
    // its latched address and command
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          next_addr = 16'h0000;
          next_cmd  = 8'h00;
        end
        1: begin
          next_addr = 16'hFFFF;
          next_cmd  = 8'hFF;
        end
        default: begin
          next_addr = 16'($urandom_range(0, 16'hFFFF));
          next_cmd  = 8'($urandom_range(0, 8'hFF));
        end
      endcase
      write_reg(REG_DEVICE_ADDRESS, {16'd0, next_addr});
      write_reg(REG_COMMAND_CODE, {24'd0, next_cmd});
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if (i % 50 == 0) begin
          tx_idle_on = (p != 1) && ($urandom_range(0, 2) != 0);
          rx_idle_on <= (p != 1) && ($urandom_range(0, 2) != 0);
        end
        send_tick($urandom_range(0, 99) < req_pct[p], 1'b0, R_IDLE);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Run covered %0d ticks, %0d complete frames and %0d register writes,",
             ticks_checked, frames_done, reg_writes);
    $display("with zero, all-ones and random address/command settings.");
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== ir_frame_transmitter.f =====
design/irft_pkg.sv
design/irft_seq.sv
design/irft_out.sv
design/ir_frame_transmitter.sv
sim/tb_ir_frame_transmitter.sv
